>>> rtl/dld_pkg.sv
`timescale 1ns / 1ps
package dld_pkg;

  localparam int OP_W        = 3;
  localparam int STATUS_W    = 2;
  localparam int VALUE_W     = 32;
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic [OP_W-1:0] {
    OP_PUSH_FRONT = 3'd0,
    OP_PUSH_BACK  = 3'd1,
    OP_POP_FRONT  = 3'd2,
    OP_POP_BACK   = 3'd3,
    OP_REMOVE     = 3'd4,
    OP_READ_OUT   = 3'd5
  } op_t;

  typedef enum logic [STATUS_W-1:0] {
    STAT_OK        = 2'd0,
    STAT_EMPTY     = 2'd1,
    STAT_NOT_FOUND = 2'd2,
    STAT_FULL      = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_INS_LINK,
    ST_UNLINK,
    ST_WALK,
    ST_RESP
  } state_t;

  // Head of the command queue as seen by the execution side.
  typedef struct packed {
    logic valid;
    op_t  op;
  } cmd_t;

endpackage

>>> rtl/dld_front.sv
`timescale 1ns / 1ps
module dld_front #(
  parameter int DATA_WIDTH = 32
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic [dld_pkg::OP_W-1:0]           op,
  input  logic signed [dld_pkg::VALUE_W-1:0] value,
  output dld_pkg::cmd_t                      cmd,
  output logic [DATA_WIDTH-1:0]              cmd_data,
  input  logic                               cmd_pop
);

  dld_pkg::op_t            q_op   [dld_pkg::QUEUE_DEPTH];
  logic [DATA_WIDTH-1:0]   q_data [dld_pkg::QUEUE_DEPTH];
  logic [dld_pkg::QPTR_W-1:0] wr_ptr;
  logic [dld_pkg::QPTR_W-1:0] rd_ptr;
  logic [dld_pkg::QCNT_W-1:0] q_count;

  logic                  legal;
  logic                  push;
  logic signed [63:0]    value_wide;
  logic [DATA_WIDTH-1:0] value_fit;

  // Classify: codes outside the operation set are accepted and dropped.
  always_comb begin
    unique case (op) inside
      dld_pkg::OP_PUSH_FRONT, dld_pkg::OP_PUSH_BACK, dld_pkg::OP_POP_FRONT,
      dld_pkg::OP_POP_BACK, dld_pkg::OP_REMOVE, dld_pkg::OP_READ_OUT: legal = 1'b1;
      default: legal = 1'b0;
    endcase
  end

  // Sign-extend, then keep the stored width.
  assign value_wide = 64'(value);
  assign value_fit  = value_wide[DATA_WIDTH-1:0];

  assign in_ready = (q_count != dld_pkg::QCNT_W'(dld_pkg::QUEUE_DEPTH));
  assign push     = in_valid && in_ready && legal;

  assign cmd.valid = (q_count != '0);
  assign cmd.op    = q_op[rd_ptr];
  assign cmd_data  = q_data[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      q_op[wr_ptr]   <= dld_pkg::op_t'(op);
      q_data[wr_ptr] <= value_fit;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr  <= '0;
      rd_ptr  <= '0;
      q_count <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + dld_pkg::QPTR_W'(1);
      if (cmd_pop) rd_ptr <= rd_ptr + dld_pkg::QPTR_W'(1);
      if (push && !cmd_pop) begin
        q_count <= q_count + dld_pkg::QCNT_W'(1);
      end else if (!push && cmd_pop) begin
        q_count <= q_count - dld_pkg::QCNT_W'(1);
      end
    end
  end

endmodule

>>> rtl/dld_back.sv
`timescale 1ns / 1ps
module dld_back #(
  parameter int DEPTH      = 16,
  parameter int DATA_WIDTH = 32
) (
  input  logic                                clk,
  input  logic                                rst,
  input  dld_pkg::cmd_t                       cmd,
  input  logic [DATA_WIDTH-1:0]               cmd_data,
  output logic                                cmd_pop,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [dld_pkg::STATUS_W-1:0]        status,
  output logic signed [dld_pkg::VALUE_W-1:0]  element,
  output logic                                last
);

  localparam int AW = $clog2(DEPTH);
  localparam int SW = $clog2(DEPTH + 1);
  localparam logic [SW-1:0] NIL = SW'(DEPTH);

  function automatic logic slot_ok(input logic [SW-1:0] s);
    return s < NIL;
  endfunction

  // Link table: one write port per array, one shared registered read port.
  logic [DATA_WIDTH-1:0] entry_values [DEPTH];
  logic [SW-1:0]         next_links   [DEPTH];
  logic [SW-1:0]         prev_links   [DEPTH];

  dld_pkg::state_t  state, state_next;
  logic [SW-1:0]    head_slot, head_slot_next;
  logic [SW-1:0]    tail_slot, tail_slot_next;
  logic [DEPTH-1:0] free_slots, free_slots_next;
  logic [SW-1:0]    entry_count, entry_count_next;
  logic [SW-1:0]    slot, slot_next;
  logic [AW-1:0]    steps, steps_next;
  dld_pkg::op_t     cmd_op, cmd_op_next;
  logic [DATA_WIDTH-1:0] val, val_next;
  dld_pkg::status_t resp_status, resp_status_next;

  logic                  rd_en;
  logic [AW-1:0]         rd_addr;
  logic [DATA_WIDTH-1:0] rd_val;
  logic [SW-1:0]         rd_next;
  logic [SW-1:0]         rd_prev;

  logic                  vl_we;
  logic [AW-1:0]         vl_wa;
  logic [DATA_WIDTH-1:0] vl_wd;
  logic                  nx_we;
  logic [AW-1:0]         nx_wa;
  logic [SW-1:0]         nx_wd;
  logic                  pv_we;
  logic [AW-1:0]         pv_wa;
  logic [SW-1:0]         pv_wd;

  logic                        out_free;
  logic                        emit;
  dld_pkg::status_t            emit_status;
  logic [dld_pkg::VALUE_W-1:0] emit_element;
  logic                        emit_last;

  logic [SW-1:0]      low_free;
  logic [SW-1:0]      pop_target;
  logic               walk_end;
  logic signed [63:0] rd_wide;

  assign out_free = !out_valid || out_ready;
  assign rd_wide  = 64'(signed'(rd_val));
  assign walk_end = !slot_ok(rd_next) || (steps == AW'(DEPTH - 1));
  assign pop_target = (cmd.op == dld_pkg::OP_POP_FRONT) ? head_slot : tail_slot;

  // Lowest free slot, NIL when the table is full.
  always_comb begin
    low_free = NIL;
    for (int i = DEPTH - 1; i >= 0; i--) begin
      if (free_slots[i]) low_free = SW'(i);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= dld_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next       = state;
    head_slot_next   = head_slot;
    tail_slot_next   = tail_slot;
    free_slots_next  = free_slots;
    entry_count_next = entry_count;
    slot_next        = slot;
    steps_next       = steps;
    cmd_op_next      = cmd_op;
    val_next         = val;
    resp_status_next = resp_status;
    cmd_pop          = 1'b0;
    rd_en            = 1'b0;
    rd_addr          = head_slot[AW-1:0];
    vl_we            = 1'b0;
    vl_wa            = low_free[AW-1:0];
    vl_wd            = cmd_data;
    nx_we            = 1'b0;
    nx_wa            = low_free[AW-1:0];
    nx_wd            = NIL;
    pv_we            = 1'b0;
    pv_wa            = low_free[AW-1:0];
    pv_wd            = NIL;
    emit             = 1'b0;
    emit_status      = resp_status;
    emit_element     = '0;
    emit_last        = 1'b1;

    unique case (state)
      dld_pkg::ST_IDLE: begin
        if (cmd.valid) begin
          cmd_pop     = 1'b1;
          cmd_op_next = cmd.op;
          val_next    = cmd_data;
          unique case (cmd.op) inside
            dld_pkg::OP_PUSH_FRONT, dld_pkg::OP_PUSH_BACK: begin
              if (!slot_ok(low_free)) begin
                resp_status_next = dld_pkg::STAT_FULL;
                state_next       = dld_pkg::ST_RESP;
              end else begin
                // Fill the new slot; the neighbor link follows next cycle.
                slot_next = low_free;
                vl_we     = 1'b1;
                nx_we     = 1'b1;
                pv_we     = 1'b1;
                if (cmd.op == dld_pkg::OP_PUSH_FRONT) begin
                  nx_wd = head_slot;
                end else begin
                  pv_wd = tail_slot;
                end
                state_next = dld_pkg::ST_INS_LINK;
              end
            end
            dld_pkg::OP_POP_FRONT, dld_pkg::OP_POP_BACK: begin
              if (!slot_ok(pop_target)) begin
                resp_status_next = dld_pkg::STAT_EMPTY;
                state_next       = dld_pkg::ST_RESP;
              end else begin
                rd_en      = 1'b1;
                rd_addr    = pop_target[AW-1:0];
                slot_next  = pop_target;
                state_next = dld_pkg::ST_UNLINK;
              end
            end
            dld_pkg::OP_REMOVE, dld_pkg::OP_READ_OUT: begin
              if (!slot_ok(head_slot)) begin
                resp_status_next = dld_pkg::STAT_EMPTY;
                state_next       = dld_pkg::ST_RESP;
              end else begin
                rd_en      = 1'b1;
                rd_addr    = head_slot[AW-1:0];
                slot_next  = head_slot;
                steps_next = '0;
                state_next = dld_pkg::ST_WALK;
              end
            end
            default: state_next = dld_pkg::ST_IDLE;
          endcase
        end
      end

      dld_pkg::ST_INS_LINK: begin
        if (slot_ok(head_slot) && slot_ok(tail_slot)) begin
          if (cmd_op == dld_pkg::OP_PUSH_FRONT) begin
            pv_we          = 1'b1;
            pv_wa          = head_slot[AW-1:0];
            pv_wd          = slot;
            head_slot_next = slot;
          end else begin
            nx_we          = 1'b1;
            nx_wa          = tail_slot[AW-1:0];
            nx_wd          = slot;
            tail_slot_next = slot;
          end
        end else begin
          head_slot_next = slot;
          tail_slot_next = slot;
        end
        free_slots_next[slot[AW-1:0]] = 1'b0;
        entry_count_next = entry_count + SW'(1);
        resp_status_next = dld_pkg::STAT_OK;
        state_next       = dld_pkg::ST_RESP;
      end

      dld_pkg::ST_UNLINK: begin
        // Read data of the slot is held from the previous read.
        if (slot_ok(rd_prev)) begin
          nx_we = 1'b1;
          nx_wa = rd_prev[AW-1:0];
          nx_wd = rd_next;
        end else begin
          head_slot_next = rd_next;
        end
        if (slot_ok(rd_next)) begin
          pv_we = 1'b1;
          pv_wa = rd_next[AW-1:0];
          pv_wd = rd_prev;
        end else begin
          tail_slot_next = rd_prev;
        end
        free_slots_next[slot[AW-1:0]] = 1'b1;
        if (entry_count != '0) entry_count_next = entry_count - SW'(1);
        resp_status_next = dld_pkg::STAT_OK;
        state_next       = dld_pkg::ST_RESP;
      end

      dld_pkg::ST_WALK: begin
        if (cmd_op == dld_pkg::OP_REMOVE) begin
          if (rd_val == val) begin
            state_next = dld_pkg::ST_UNLINK;
          end else if (walk_end) begin
            resp_status_next = dld_pkg::STAT_NOT_FOUND;
            state_next       = dld_pkg::ST_RESP;
          end else begin
            rd_en      = 1'b1;
            rd_addr    = rd_next[AW-1:0];
            slot_next  = rd_next;
            steps_next = steps + AW'(1);
          end
        end else if (out_free) begin
          emit         = 1'b1;
          emit_status  = dld_pkg::STAT_OK;
          emit_element = rd_wide[dld_pkg::VALUE_W-1:0];
          emit_last    = walk_end;
          if (walk_end) begin
            state_next = dld_pkg::ST_IDLE;
          end else begin
            rd_en      = 1'b1;
            rd_addr    = rd_next[AW-1:0];
            slot_next  = rd_next;
            steps_next = steps + AW'(1);
          end
        end
      end

      dld_pkg::ST_RESP: begin
        if (out_free) begin
          emit       = 1'b1;
          state_next = dld_pkg::ST_IDLE;
        end
      end

      default: state_next = dld_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head_slot   <= NIL;
      tail_slot   <= NIL;
      free_slots  <= '1;
      entry_count <= '0;
    end else begin
      head_slot   <= head_slot_next;
      tail_slot   <= tail_slot_next;
      free_slots  <= free_slots_next;
      entry_count <= entry_count_next;
    end
  end

  always_ff @(posedge clk) begin
    slot        <= slot_next;
    steps       <= steps_next;
    cmd_op      <= cmd_op_next;
    val         <= val_next;
    resp_status <= resp_status_next;
  end

  always_ff @(posedge clk) begin
    if (vl_we) entry_values[vl_wa] <= vl_wd;
    if (nx_we) next_links[nx_wa] <= nx_wd;
    if (pv_we) prev_links[pv_wa] <= pv_wd;
    if (rd_en) begin
      rd_val  <= entry_values[rd_addr];
      rd_next <= next_links[rd_addr];
      rd_prev <= prev_links[rd_addr];
    end
  end

  // Result register: hold until taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      status  <= emit_status;
      element <= emit_element;
      last    <= emit_last;
    end
  end

  a_count_matches_free: assert property (@(posedge clk) disable iff (rst)
    $countones(free_slots) + int'(entry_count) == DEPTH)
    else $error("entry count disagrees with free-slot map");

  a_ends_agree: assert property (@(posedge clk) disable iff (rst)
    slot_ok(head_slot) == slot_ok(tail_slot))
    else $error("head and tail disagree on list emptiness");

  a_empty_means_no_head: assert property (@(posedge clk) disable iff (rst)
    (entry_count == '0) == (head_slot == NIL))
    else $error("entry count and head pointer disagree");

  a_partial_only_in_readout: assert property (@(posedge clk) disable iff (rst)
    out_valid && !last |-> state == dld_pkg::ST_WALK && cmd_op == dld_pkg::OP_READ_OUT)
    else $error("non-final result outside a read-out");

endmodule

>>> rtl/doubly_linked_deque.sv
`timescale 1ns / 1ps
// Bounded doubly linked deque kept in a DEPTH-slot link table.
//
// Input channel (in_valid / in_ready, op, value): one request per handshake.
// Ops: push front, push back, pop front, pop back, remove first match (from
// the head), read out head to tail. Codes 6 and 7 are accepted and dropped.
// Output channel (out_valid / out_ready, status, element, last): every op but
// read-out gives one status result with last set; read-out gives one result
// per entry, last on the tail, or a single empty result on an empty list.
//
// A two-entry request queue sits between the front (accept, classify) and
// the execution engine, so requests keep arriving while the engine works.
// Engine steps: push fills the new slot, then links it; pop reads the slot,
// then unlinks it; remove walks from the head to a match, then unlinks it;
// read-out walks head to tail, one entry per cycle while results are taken,
// through the table's single registered read port. Full/empty give status only.
//
// Reset (rst, synchronous) empties the list and frees every slot; table
// contents are left as they are. When the receiver stalls, the result
// register holds and the engine waits; the queue fills and in_ready drops.
module doubly_linked_deque #(
  parameter int DEPTH      = 16,
  parameter int DATA_WIDTH = 32
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [dld_pkg::OP_W-1:0]            op,
  input  logic signed [dld_pkg::VALUE_W-1:0]  value,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [dld_pkg::STATUS_W-1:0]        status,
  output logic signed [dld_pkg::VALUE_W-1:0]  element,
  output logic                                last
);

  dld_pkg::cmd_t         cmd;
  logic [DATA_WIDTH-1:0] cmd_data;
  logic                  cmd_pop;

  // Front: accept, drop unknown codes, fit the value, queue the request.
  dld_front #(
    .DATA_WIDTH (DATA_WIDTH)
  ) u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .op       (op),
    .value    (value),
    .cmd      (cmd),
    .cmd_data (cmd_data),
    .cmd_pop  (cmd_pop)
  );

  // Back: link table, free map and the sequencer that walks and relinks.
  dld_back #(
    .DEPTH      (DEPTH),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .cmd_data  (cmd_data),
    .cmd_pop   (cmd_pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .status    (status),
    .element   (element),
    .last      (last)
  );

endmodule
